[src/rwdb_pkg.sv]
// Shared types, constants and a helper function of the register write dedup batcher.
package rwdb_pkg;

	localparam int NUM_REGS   = 512;
	localparam int IDX_W      = $clog2(NUM_REGS);
	localparam int ADDR_W     = 9;
	localparam int DELTA_W    = 14;
	localparam int DELTA_MAX  = 16383;
	localparam int CAP_LIMIT  = 40;
	localparam int EPOCH_W    = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// Request types.
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_RESET = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	// Result kinds.
	localparam logic [1:0] OUT_WRITE = 2'd0;
	localparam logic [1:0] OUT_CLOSE = 2'd1;
	localparam logic [1:0] OUT_RESET = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS_OUTPUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRITES      = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ADDR_W-1:0] reg_addr;
		logic [7:0]        reg_value;
		logic [31:0]       time_stamp;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         out_kind;
		logic [ADDR_W-1:0]  out_addr;
		logic [7:0]         out_value;
		logic               starts_batch;
		logic [DELTA_W-1:0] batch_delta;
		logic               is_last;
	} rsp_item_t;

	// One shadow entry: it is valid only while its epoch matches the current one.
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [7:0]         value;
	} shadow_word_t;

	// Shadow index of a register address. NUM_REGS is a power of two, so the
	// remainder is simply the low address bits.
	function automatic logic [IDX_W-1:0] shadow_index(input logic [ADDR_W-1:0] addr);
		logic [31:0] a;
		a = 32'(addr);
		return a[IDX_W-1:0];
	endfunction

endpackage

[src/rwdb_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module rwdb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/register_write_dedup_batcher.sv]
// Top level of the register write dedup batcher: shadow RAM, batch state and result queue.
//
// One request transaction is taken per clock cycle while the four-entry result queue has room
// for the two results a request can cause and no epoch wrap holds back a reset; results leave
// at one per cycle while rsp_ready is high, so a steady stream of requests that each cause one
// result runs at one per cycle. A taken request waits in stage 1, where the shadow RAM read
// returns and the batch decision is made on the read data; its results enter the queue at the
// edge where stage 1 fires, with the write back forwarded to a request that follows directly.
// After reset, and again on every 255th active chip reset, a clearing pass sweeps all NUM_REGS
// (512) shadow entries and no request is taken; configuration writes are taken throughout.
module register_write_dedup_batcher (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  rwdb_pkg::req_item_t                 req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output rwdb_pkg::rsp_item_t                 rsp,
	input  logic                                cfg_we,
	input  logic [rwdb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rwdb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Configuration.
	logic       fwd_en_q;
	logic       suppress_q;
	logic [5:0] max_wr_q;

	// Stage 1: request waiting on its shadow read.
	logic                          valid_s1;
	rwdb_pkg::req_item_t           req_s1;
	logic [rwdb_pkg::IDX_W-1:0]    idx_s1;

	// Shadow epoch, clearing pass and write forwarding.
	logic [rwdb_pkg::EPOCH_W-1:0]  epoch_q;
	logic                          clear_q;
	logic [rwdb_pkg::IDX_W-1:0]    clr_idx_q;
	logic                          fwd_valid_q;
	logic [rwdb_pkg::IDX_W-1:0]    fwd_idx_q;
	rwdb_pkg::shadow_word_t        fwd_word_q;

	// Batch state.
	logic [5:0]  batch_count_q;
	logic [31:0] open_stamp_q;
	logic [31:0] prev_stamp_q;
	logic        first_q;

	// Result queue.
	rwdb_pkg::rsp_item_t           fifo_q [rwdb_pkg::FIFO_DEPTH];
	logic [rwdb_pkg::FIFO_AW-1:0]  head_q;
	logic [rwdb_pkg::FIFO_AW-1:0]  tail_q;
	logic [rwdb_pkg::FIFO_CW-1:0]  count_q;

	// RAM ports.
	logic                          ram_we;
	logic [rwdb_pkg::IDX_W-1:0]    ram_waddr;
	rwdb_pkg::shadow_word_t        ram_wdata;
	logic [rwdb_pkg::IDX_W-1:0]    ram_raddr;
	rwdb_pkg::shadow_word_t        ram_rdata;

	// Stage 1 decision.
	logic                          active;
	logic                          s1_fire;
	logic                          req_fire;
	logic                          rsp_fire;
	logic                          wrap_block;
	logic [rwdb_pkg::IDX_W-1:0]    in_idx;
	rwdb_pkg::shadow_word_t        cur_word;
	logic                          dup;
	logic [5:0]                    cap;
	logic                          close_first;
	logic [5:0]                    count_mid;
	logic [5:0]                    count_inc;
	logic                          close_after;
	logic                          stamp_later;
	logic [31:0]                   stamp_diff;
	logic [rwdb_pkg::DELTA_W-1:0]  delta;
	rwdb_pkg::rsp_item_t           res0;
	rwdb_pkg::rsp_item_t           res1;
	logic [1:0]                    n_res;
	logic                          shadow_we;
	logic                          clear_start;
	logic [5:0]                    batch_count_d;
	logic [31:0]                   open_stamp_d;
	logic [31:0]                   prev_stamp_d;
	logic                          first_d;
	logic [rwdb_pkg::EPOCH_W-1:0]  epoch_d;

	assign active   = fwd_en_q && !suppress_q;
	assign s1_fire  = valid_s1 && (count_q <= rwdb_pkg::FIFO_CW'(rwdb_pkg::FIFO_DEPTH - 2));
	assign wrap_block = valid_s1 && (req_s1.req_type == rwdb_pkg::REQ_RESET) && active
		&& (epoch_q == '1);
	assign req_ready = !clear_q && !wrap_block && (!valid_s1 || s1_fire);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = (count_q != '0);
	assign rsp       = fifo_q[head_q];
	assign rsp_fire  = rsp_valid && rsp_ready;

	assign in_idx    = rwdb_pkg::shadow_index(req.reg_addr);
	assign ram_raddr = req_fire ? in_idx : idx_s1;

	rwdb_ram #(
		.WIDTH($bits(rwdb_pkg::shadow_word_t)),
		.DEPTH(rwdb_pkg::NUM_REGS)
	) u_shadow (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The write issued at the edge that read this entry is not yet in the RAM data.
	assign cur_word = (fwd_valid_q && fwd_idx_q == idx_s1) ? fwd_word_q : ram_rdata;
	assign dup      = (cur_word.epoch == epoch_q) && (cur_word.value == req_s1.reg_value);

	assign cap = (max_wr_q == '0) ? 6'd1 :
		(max_wr_q > 6'(rwdb_pkg::CAP_LIMIT)) ? 6'(rwdb_pkg::CAP_LIMIT) : max_wr_q;

	assign close_first = (batch_count_q != '0)
		&& (req_s1.time_stamp != open_stamp_q || batch_count_q >= cap);
	assign count_mid   = close_first ? 6'd0 : batch_count_q;
	assign count_inc   = count_mid + 6'd1;
	assign close_after = (count_inc >= cap) && !close_first;

	assign stamp_later = req_s1.time_stamp > prev_stamp_q;
	assign stamp_diff  = req_s1.time_stamp - prev_stamp_q;
	assign delta = (first_q || !stamp_later) ? '0 :
		(stamp_diff > 32'(rwdb_pkg::DELTA_MAX)) ? rwdb_pkg::DELTA_W'(rwdb_pkg::DELTA_MAX) :
		stamp_diff[rwdb_pkg::DELTA_W-1:0];

	always_comb begin
		rwdb_pkg::rsp_item_t wr_res;
		rwdb_pkg::rsp_item_t close_res;
		rwdb_pkg::rsp_item_t reset_res;

		wr_res              = '0;
		wr_res.out_kind     = rwdb_pkg::OUT_WRITE;
		wr_res.out_addr     = req_s1.reg_addr;
		wr_res.out_value    = req_s1.reg_value;
		wr_res.starts_batch = (count_mid == '0);
		wr_res.batch_delta  = (count_mid == '0) ? delta : '0;
		close_res           = '0;
		close_res.out_kind  = rwdb_pkg::OUT_CLOSE;
		reset_res           = '0;
		reset_res.out_kind  = rwdb_pkg::OUT_RESET;

		res0          = '0;
		res1          = '0;
		n_res         = 2'd0;
		shadow_we     = 1'b0;
		clear_start   = 1'b0;
		batch_count_d = batch_count_q;
		open_stamp_d  = open_stamp_q;
		prev_stamp_d  = prev_stamp_q;
		first_d       = first_q;
		epoch_d       = epoch_q;

		if (s1_fire) begin
			unique case (req_s1.req_type)
				rwdb_pkg::REQ_WRITE: begin
					if (active && !dup) begin
						shadow_we = 1'b1;
						if (count_mid == '0) begin
							prev_stamp_d = req_s1.time_stamp;
							open_stamp_d = req_s1.time_stamp;
							first_d      = 1'b0;
						end
						batch_count_d = close_after ? 6'd0 : count_inc;
						if (close_first) begin
							res0  = close_res;
							res1  = wr_res;
							n_res = 2'd2;
						end else if (close_after) begin
							res0  = wr_res;
							res1  = close_res;
							n_res = 2'd2;
						end else begin
							res0  = wr_res;
							n_res = 2'd1;
						end
					end
				end
				rwdb_pkg::REQ_RESET: begin
					if (active) begin
						batch_count_d = '0;
						first_d       = 1'b1;
						// Bumping the epoch invalidates every entry; on wrap the RAM is swept.
						if (epoch_q == '1) begin
							epoch_d     = rwdb_pkg::EPOCH_W'(1);
							clear_start = 1'b1;
						end else begin
							epoch_d = epoch_q + rwdb_pkg::EPOCH_W'(1);
						end
						if (batch_count_q != '0) begin
							res0  = close_res;
							res1  = reset_res;
							n_res = 2'd2;
						end else begin
							res0  = reset_res;
							n_res = 2'd1;
						end
					end
				end
				rwdb_pkg::REQ_FLUSH: begin
					if (batch_count_q != '0) begin
						batch_count_d = '0;
						res0          = close_res;
						n_res         = 2'd1;
					end
				end
				default: begin
				end
			endcase
		end

		if (n_res == 2'd1) begin
			res0.is_last = 1'b1;
		end
		if (n_res == 2'd2) begin
			res1.is_last = 1'b1;
		end
	end

	always_comb begin
		if (clear_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else begin
			ram_we          = shadow_we;
			ram_waddr       = idx_s1;
			ram_wdata.epoch = epoch_q;
			ram_wdata.value = req_s1.reg_value;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q      <= 1'b1;
			suppress_q    <= 1'b0;
			max_wr_q      <= 6'(rwdb_pkg::CAP_LIMIT);
			valid_s1      <= 1'b0;
			epoch_q       <= rwdb_pkg::EPOCH_W'(1);
			clear_q       <= 1'b1;
			clr_idx_q     <= '0;
			fwd_valid_q   <= 1'b0;
			batch_count_q <= '0;
			open_stamp_q  <= '0;
			prev_stamp_q  <= '0;
			first_q       <= 1'b1;
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rwdb_pkg::CFG_FORWARD_ENABLE:  fwd_en_q   <= cfg_data[0];
					rwdb_pkg::CFG_SUPPRESS_OUTPUT: suppress_q <= cfg_data[0];
					rwdb_pkg::CFG_MAX_WRITES:      max_wr_q   <= cfg_data;
					default: begin
					end
				endcase
			end

			if (req_ready) begin
				valid_s1 <= req_valid;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end

			epoch_q       <= epoch_d;
			batch_count_q <= batch_count_d;
			open_stamp_q  <= open_stamp_d;
			prev_stamp_q  <= prev_stamp_d;
			first_q       <= first_d;

			if (clear_start) begin
				clear_q   <= 1'b1;
				clr_idx_q <= '0;
			end else if (clear_q) begin
				clr_idx_q <= clr_idx_q + rwdb_pkg::IDX_W'(1);
				if (clr_idx_q == rwdb_pkg::IDX_W'(rwdb_pkg::NUM_REGS - 1)) begin
					clear_q <= 1'b0;
				end
			end

			if (clear_q || clear_start) begin
				fwd_valid_q <= 1'b0;
			end else if (shadow_we) begin
				fwd_valid_q <= 1'b1;
			end

			head_q  <= rsp_fire ? head_q + rwdb_pkg::FIFO_AW'(1) : head_q;
			tail_q  <= tail_q + rwdb_pkg::FIFO_AW'(n_res);
			count_q <= count_q + rwdb_pkg::FIFO_CW'(n_res)
				- rwdb_pkg::FIFO_CW'(rsp_fire);
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req;
			idx_s1 <= in_idx;
		end
		if (shadow_we) begin
			fwd_idx_q  <= idx_s1;
			fwd_word_q <= ram_wdata;
		end
		if (n_res != 2'd0) begin
			fifo_q[tail_q] <= res0;
		end
		if (n_res == 2'd2) begin
			fifo_q[tail_q + rwdb_pkg::FIFO_AW'(1)] <= res1;
		end
	end

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rwdb_pkg::FIFO_CW'(rwdb_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !valid_s1 && !req_ready)
		else $error("request in flight during shadow clearing pass");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |=> valid_s1 && $stable(req_s1))
		else $error("stalled stage 1 request lost or changed");

	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("current epoch equals the cleared-entry mark");

endmodule
